/* rtl/particle_surface_absorber_core_macros.svh */
// Assertion macros for the particle surface absorber.
// Included by the top level; no other dependencies.
`ifndef PARTICLE_SURFACE_ABSORBER_CORE_MACROS_SVH
`define PARTICLE_SURFACE_ABSORBER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define PSA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PSA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg)
`define PSA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

/* rtl/psa_pkg.sv */
// Shared types and constants for the particle surface absorber.
// No dependencies; used by every module of the block.
package psa_pkg;

  localparam int DATA_W     = 32;
  localparam int IN_DATA_W  = 6 * DATA_W;
  localparam int LOST_CNT_W = 24;
  localparam int SUM_W      = 64;
  localparam int OUT_PAD_W  = 7;
  localparam int OUT_DATA_W = OUT_PAD_W + SUM_W + LOST_CNT_W + 1;
  localparam int CFG_IDX_W  = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_Z  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Y = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_Z = 3'd7;

  // Shape codes.
  localparam logic [1:0] SHAPE_BOX       = 2'd0;
  localparam logic [1:0] SHAPE_ELLIPSOID = 2'd1;
  localparam logic [1:0] SHAPE_CYLINDER  = 2'd2;

  // Axis codes.
  localparam logic [1:0] AXIS_X      = 2'd0;
  localparam logic [1:0] AXIS_Y      = 2'd1;
  localparam logic [1:0] AXIS_Z      = 2'd2;
  localparam logic [1:0] AXIS_UNUSED = 2'd3;

  // Fixed-point 1.0 in Q.16 and Q.32.
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // Reset values of the bounds.
  localparam logic [DATA_W-1:0] LOW_RESET  = 32'h0000_0000;
  localparam logic [DATA_W-1:0] HIGH_RESET = 32'h0001_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       a_en;
    logic [1:0] a_axis;
    logic       b_en;
    logic [1:0] b_axis;
    logic       c_en;
    logic [1:0] c_axis;
    logic       finish;
    logic       div_start;
    logic       geom_wr;
    logic [1:0] geom_axis;
  } psa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } psa_stat_t;

endpackage

/* rtl/psa_div.sv */
// Restoring divider for the scale factor: 2^(17+FRAC_BITS) / divisor, saturated.
// One quotient bit per cycle. Depends on psa_pkg.
module psa_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [psa_pkg::DATA_W-1:0]  divisor,
  output logic                        done,
  output logic [psa_pkg::DATA_W-1:0]  quotient
);

  localparam int QW = 18 + FRAC_BITS;
  localparam int CW = $clog2(QW);

  logic                       busy_r, busy_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [psa_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [psa_pkg::DATA_W-1:0] div_r, div_nxt;
  logic [QW-1:0]              quo_r, quo_nxt;
  logic                       zero_r, zero_nxt;
  logic [psa_pkg::DATA_W:0]   trial;
  logic                       bit_in;
  logic                       ge;
  logic [QW-1:0]              quo_step;

  // One restoring step: the dividend has a single one at its top bit.
  always_comb begin
    bit_in   = (cnt_r == CW'(QW - 1));
    trial    = {rem_r, bit_in};
    ge       = (trial >= {1'b0, div_r});
    quo_step = {quo_r[QW-2:0], ge};
  end

  assign done = busy_r && (cnt_r == '0);

  // Saturate a zero divisor or a quotient that needs more than 32 bits.
  always_comb begin
    if (zero_r || (64'(quo_step) > 64'h0000_0000_FFFF_FFFF)) begin
      quotient = '1;
    end else begin
      quotient = psa_pkg::DATA_W'(quo_step);
    end
  end

  // Next-state logic.
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW - 1);
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = '0;
      zero_nxt = (divisor == '0);
    end else if (busy_r) begin
      rem_nxt = ge ? psa_pkg::DATA_W'(trial - {1'b0, div_r})
                   : psa_pkg::DATA_W'(trial);
      quo_nxt = quo_step;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quo_r  <= quo_nxt;
    zero_r <= zero_nxt;
  end

endmodule

/* rtl/psa_dp.sv */
// Datapath of the particle surface absorber: bounds, geometry, per-axis
// multiply stages, batch totals and the output register. Depends on psa_pkg, psa_div.
module psa_dp #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  psa_pkg::psa_cmd_t                    cmd,
  output psa_pkg::psa_stat_t                   stat,
  input  logic                                 cfg_we,
  input  logic [psa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [psa_pkg::DATA_W-1:0]           cfg_wdata,
  input  logic [psa_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [psa_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                 out_tlast
);

  localparam int DW = psa_pkg::DATA_W;

  // Configuration registers.
  logic [1:0]           shape_r;
  logic [1:0]           cyl_axis_r;
  logic signed [DW-1:0] low_r  [3];
  logic signed [DW-1:0] high_r [3];

  // Geometry.
  logic signed [DW-1:0] center_r [3];
  logic [DW-1:0]        scale_r  [3];

  // Item registers.
  logic signed [DW-1:0] pos_r [3];
  logic signed [DW-1:0] vel_r [3];
  logic                 last_r;

  // Pipeline registers.
  logic [48:0]          prod_lo_r, prod_hi_r;
  logic [63:0]          vsq_r;
  logic [2:0]           rng_ok_r;
  logic [16:0]          t_r;
  logic                 over_r;
  logic [63:0]          v2_acc_r;
  logic [35:0]          rad_acc_r;
  logic                 over_any_r;

  // Batch totals and output register.
  logic [COUNT_BITS-1:0] count_acc_r, count_acc_nxt;
  logic [63:0]           speed_acc_r, speed_acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_abs_r;
  logic [psa_pkg::LOST_CNT_W-1:0] out_cnt_r;
  logic [63:0]           out_sum_r;
  logic                  out_last_r;

  // Divider hookup and geometry of the selected axis.
  logic                 div_done;
  logic [DW-1:0]        div_quo;
  logic signed [DW:0]   ext_diff;
  logic signed [DW:0]   ext_sum;
  logic [DW:0]          ext_mag;
  logic [DW-1:0]        divisor;

  always_comb begin
    ext_diff = {high_r[cmd.geom_axis][DW-1], high_r[cmd.geom_axis]}
             - {low_r[cmd.geom_axis][DW-1], low_r[cmd.geom_axis]};
    ext_sum  = {high_r[cmd.geom_axis][DW-1], high_r[cmd.geom_axis]}
             + {low_r[cmd.geom_axis][DW-1], low_r[cmd.geom_axis]};
    ext_mag  = ext_diff[DW] ? (DW+1)'(-ext_diff) : ext_diff;
    divisor  = DW'(ext_mag);
  end

  psa_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r    <= psa_pkg::SHAPE_BOX;
      cyl_axis_r <= psa_pkg::AXIS_Z;
      for (int a = 0; a < 3; a++) begin
        low_r[a]  <= psa_pkg::LOW_RESET;
        high_r[a] <= psa_pkg::HIGH_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        psa_pkg::REG_SHAPE:  shape_r    <= cfg_wdata[1:0];
        psa_pkg::REG_AXIS:   cyl_axis_r <= cfg_wdata[1:0];
        psa_pkg::REG_LOW_X:  low_r[0]   <= cfg_wdata;
        psa_pkg::REG_LOW_Y:  low_r[1]   <= cfg_wdata;
        psa_pkg::REG_LOW_Z:  low_r[2]   <= cfg_wdata;
        psa_pkg::REG_HIGH_X: high_r[0]  <= cfg_wdata;
        psa_pkg::REG_HIGH_Y: high_r[1]  <= cfg_wdata;
        psa_pkg::REG_HIGH_Z: high_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Geometry write when the divider finishes an axis.
  always_ff @(posedge clk) begin
    if (cmd.geom_wr) begin
      center_r[cmd.geom_axis] <= ext_sum[DW:1];
      scale_r[cmd.geom_axis]  <= div_quo;
    end
  end

  // Capture the particle on an accepted beat.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < 3; a++) begin
        pos_r[a] <= in_tdata[DW*a +: DW];
        vel_r[a] <= in_tdata[3*DW + DW*a +: DW];
      end
      last_r <= in_tlast;
    end
  end

  // Stage A: offset from center, partial products of the scale, velocity square, range check.
  logic signed [DW:0] d_a;
  logic [DW:0]        dmag_a;
  logic [DW-1:0]      vmag_a;
  logic [DW-1:0]      s_a;

  always_comb begin
    d_a    = {pos_r[cmd.a_axis][DW-1], pos_r[cmd.a_axis]}
           - {center_r[cmd.a_axis][DW-1], center_r[cmd.a_axis]};
    dmag_a = d_a[DW] ? (DW+1)'(-d_a) : d_a;
    vmag_a = vel_r[cmd.a_axis][DW-1] ? DW'(-vel_r[cmd.a_axis]) : vel_r[cmd.a_axis];
    s_a    = scale_r[cmd.a_axis];
  end

  always_ff @(posedge clk) begin
    if (cmd.a_en) begin
      prod_lo_r <= dmag_a * s_a[15:0];
      prod_hi_r <= dmag_a * s_a[31:16];
      vsq_r     <= vmag_a * vmag_a;
      rng_ok_r[cmd.a_axis] <= (pos_r[cmd.a_axis] >= low_r[cmd.a_axis]) &&
                              (pos_r[cmd.a_axis] <= high_r[cmd.a_axis]);
    end
  end

  // Stage B: assemble the scaled offset, test against 1.0, add up speed squares.
  logic [64:0] full_b;
  logic [64:0] tsh_b;

  always_comb begin
    full_b = {prod_hi_r, 16'd0} + 65'(prod_lo_r);
    tsh_b  = full_b >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (cmd.b_en) begin
      t_r      <= tsh_b[16:0];
      over_r   <= (tsh_b > 65'(psa_pkg::ONE_Q16));
      v2_acc_r <= ((cmd.b_axis == psa_pkg::AXIS_X) ? 64'd0 : v2_acc_r) + vsq_r;
    end
  end

  // Radial mask and effective cylinder axis.
  logic [1:0] cyl_ax;
  logic [2:0] mask;

  always_comb begin
    cyl_ax = (cyl_axis_r == psa_pkg::AXIS_UNUSED) ? psa_pkg::AXIS_Z : cyl_axis_r;
    case (shape_r)
      psa_pkg::SHAPE_CYLINDER: mask = 3'b111 & ~(3'b001 << cyl_ax);
      default:                 mask = 3'b111;
    endcase
  end

  // Stage C: square of the normalized offset, summed over the radial axes.
  logic [33:0] tsq_c;

  assign tsq_c = t_r * t_r;

  always_ff @(posedge clk) begin
    if (cmd.c_en) begin
      rad_acc_r  <= ((cmd.c_axis == psa_pkg::AXIS_X) ? 36'd0 : rad_acc_r) +
                    (mask[cmd.c_axis] ? 36'(tsq_c) : 36'd0);
      over_any_r <= ((cmd.c_axis == psa_pkg::AXIS_X) ? 1'b0 : over_any_r) |
                    (mask[cmd.c_axis] & over_r);
    end
  end

  // Decision and batch totals.
  logic        radial_ok;
  logic        hit;
  logic [COUNT_BITS-1:0] count_inc;
  logic [64:0] speed_sum;
  logic [63:0] speed_sat;

  always_comb begin
    radial_ok = !over_any_r && (rad_acc_r <= 36'(psa_pkg::ONE_Q32));
    case (shape_r)
      psa_pkg::SHAPE_BOX:       hit = &rng_ok_r;
      psa_pkg::SHAPE_ELLIPSOID: hit = radial_ok;
      psa_pkg::SHAPE_CYLINDER:  hit = rng_ok_r[cyl_ax] && radial_ok;
      default:                  hit = 1'b0;
    endcase
    count_inc = (count_acc_r == '1) ? count_acc_r : count_acc_r + 1'b1;
    speed_sum = {1'b0, speed_acc_r} + {1'b0, v2_acc_r};
    speed_sat = speed_sum[64] ? '1 : speed_sum[63:0];
  end

  logic [COUNT_BITS-1:0] count_new;
  logic [63:0]           speed_new;

  always_comb begin
    count_new     = hit ? count_inc : count_acc_r;
    speed_new     = hit ? speed_sat : speed_acc_r;
    count_acc_nxt = count_acc_r;
    speed_acc_nxt = speed_acc_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      count_acc_nxt = last_r ? '0 : count_new;
      speed_acc_nxt = last_r ? '0 : speed_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_acc_r <= '0;
      speed_acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_acc_r <= count_acc_nxt;
      speed_acc_r <= speed_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_abs_r  <= hit;
      out_cnt_r  <= psa_pkg::LOST_CNT_W'(count_new);
      out_sum_r  <= speed_new;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {{psa_pkg::OUT_PAD_W{1'b0}}, out_sum_r, out_cnt_r, out_abs_r};
  assign out_tlast     = out_last_r;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_tready;

endmodule

/* rtl/psa_ctrl.sv */
// Controller of the particle surface absorber: geometry pass sequencing and
// the per-particle stage schedule. Depends on psa_pkg.
module psa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  psa_pkg::psa_stat_t            stat,
  output psa_pkg::psa_cmd_t             cmd,
  output logic                          geom_pend
);

  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_CALC       = 3'd1;
  localparam logic [2:0] ST_FINISH     = 3'd2;
  localparam logic [2:0] ST_GEOM_START = 3'd3;
  localparam logic [2:0] ST_GEOM_WAIT  = 3'd4;

  localparam logic [2:0] LAST_STEP = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       pend_r, pend_nxt;
  logic       geom_clr;

  assign in_tready = (state_r == ST_IDLE) && !pend_r;
  assign geom_pend = pend_r;

  // Stage enables follow the step counter: axis k enters stage A at step k.
  always_comb begin
    cmd           = '0;
    cmd.geom_axis = axis_r;
    cmd.a_axis    = step_r[1:0];
    cmd.b_axis    = 2'(step_r - 3'd1);
    cmd.c_axis    = 2'(step_r - 3'd2);
    if (state_r == ST_CALC) begin
      cmd.a_en = (step_r <= 3'd2);
      cmd.b_en = (step_r >= 3'd1) && (step_r <= 3'd3);
      cmd.c_en = (step_r >= 3'd2);
    end
    cmd.load      = in_tvalid && in_tready;
    cmd.finish    = (state_r == ST_FINISH) && stat.out_free;
    cmd.div_start = (state_r == ST_GEOM_START);
    cmd.geom_wr   = (state_r == ST_GEOM_WAIT) && stat.div_done && !cfg_we;
  end

  // State transitions.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    axis_nxt  = axis_r;
    geom_clr  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (pend_r) begin
          state_nxt = ST_GEOM_START;
          axis_nxt  = psa_pkg::AXIS_X;
        end else if (in_tvalid) begin
          state_nxt = ST_CALC;
          step_nxt  = '0;
        end
      end
      ST_CALC: begin
        if (step_r == LAST_STEP) begin
          state_nxt = ST_FINISH;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_GEOM_START: begin
        // A bound written now would miss this start, so begin again.
        if (cfg_we) begin
          axis_nxt = psa_pkg::AXIS_X;
        end else begin
          state_nxt = ST_GEOM_WAIT;
        end
      end
      ST_GEOM_WAIT: begin
        if (cfg_we) begin
          state_nxt = ST_GEOM_START;
          axis_nxt  = psa_pkg::AXIS_X;
        end else if (stat.div_done) begin
          if (axis_r == psa_pkg::AXIS_Z) begin
            state_nxt = ST_IDLE;
            geom_clr  = 1'b1;
          end else begin
            state_nxt = ST_GEOM_START;
            axis_nxt  = axis_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Any register write asks for a new geometry pass.
  always_comb begin
    pend_nxt = pend_r;
    if (cfg_we) begin
      pend_nxt = 1'b1;
    end else if (geom_clr) begin
      pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      axis_r  <= psa_pkg::AXIS_X;
      pend_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      axis_r  <= axis_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

/* rtl/particle_surface_absorber_core.sv */
// Particle surface absorber, top level. An accepted input beat runs through the
// three-stage per-axis multiply schedule and the finish state, which waits for a
// free output register; a new particle is taken only after the finish state.
// After reset and after any register write a geometry pass runs the shared
// serial divider once per axis; in_tready stays low until it ends.
// Reset is synchronous, active low; it loads the register defaults.
`include "particle_surface_absorber_core_macros.svh"

module particle_surface_absorber_core #(
  parameter int COUNT_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata from bit 0: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each).
  input  logic [psa_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                in_tlast,
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata from bit 0: absorbed (1), lost_count (24), lost_speed_sum (64), zero pad.
  output logic [psa_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tlast,
  // Configuration port.
  input  logic                                cfg_we,
  input  logic [psa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psa_pkg::DATA_W-1:0]          cfg_wdata
);

  psa_pkg::psa_cmd_t  cmd;
  psa_pkg::psa_stat_t stat;
  logic               geom_pend;

  psa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd),
    .geom_pend (geom_pend)
  );

  psa_dp #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // A particle is never taken on stale geometry.
  `PSA_ASSERT_IMP(a_no_beat_while_pending, clk, rst_n, in_tvalid && in_tready, !geom_pend, "input beat accepted while geometry pending")

  // One particle at a time: ready drops right after an accepted beat.
  `PSA_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "second beat accepted while busy")

  // Every register write schedules a geometry pass.
  `PSA_ASSERT_NXT(a_cfg_sets_pend, clk, rst_n, cfg_we, geom_pend, "register write did not request geometry pass")

  // A result is loaded only into a free output register.
  `PSA_ASSERT_IMP(a_finish_free, clk, rst_n, cmd.finish, !out_tvalid || out_tready, "result overwrote a pending output beat")

endmodule
